// File: hdl/lsbc_pkg.sv
// ----------------------------------------------------------------------------
// Level-set boundary cleaner package
// Payload types, register indexes, label codes and the neighbor test that
// classifies one pixel of a level-set label map.
// ----------------------------------------------------------------------------
package lsbc_pkg;

    // Width of one level-set label.
    localparam int LABEL_W = 3;

    // Configuration port geometry.
    localparam int CFG_DW = 11;
    localparam int CFG_IW = 1;

    typedef logic signed [LABEL_W-1:0] t_label;
    typedef logic [CFG_IW-1:0]         t_cfg_idx;

    // Register indexes on the configuration port.
    localparam t_cfg_idx CFG_FRAME_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 1'b1;

    // Label codes.
    localparam t_label LBL_OUTSIDE     = 3'sd1;
    localparam t_label LBL_INSIDE      = -3'sd1;
    localparam t_label LBL_OUTSIDE_RED = 3'sd3;
    localparam t_label LBL_INSIDE_RED  = -3'sd3;

    // One input transfer.
    typedef struct packed {
        t_label label_in;
        logic   flush;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        t_label label_out;
        logic   last_of_frame;
    } t_out_item;

    // True when the label is strictly positive.
    function automatic logic is_pos(input t_label x);
        return !x[LABEL_W-1] && (x != '0);
    endfunction

    // Classify the center from its in-image 4-neighbors.
    function automatic t_label clean_label(
        input t_label centre,
        input logic   has_up,    input t_label up,
        input logic   has_left,  input t_label left,
        input logic   has_right, input t_label right,
        input logic   has_down,  input t_label down
    );
        logic any_nonpos;
        logic any_nonneg;
        t_label res;
        any_nonpos = (has_up && !is_pos(up)) || (has_left && !is_pos(left)) ||
                     (has_right && !is_pos(right)) || (has_down && !is_pos(down));
        any_nonneg = (has_up && !up[LABEL_W-1]) || (has_left && !left[LABEL_W-1]) ||
                     (has_right && !right[LABEL_W-1]) ||
                     (has_down && !down[LABEL_W-1]);
        res = centre;
        if (centre == LBL_OUTSIDE) begin
            res = any_nonpos ? LBL_OUTSIDE : LBL_OUTSIDE_RED;
        end else if (centre == LBL_INSIDE) begin
            res = any_nonneg ? LBL_INSIDE : LBL_INSIDE_RED;
        end
        return res;
    endfunction

endpackage

// File: hdl/level_set_boundary_cleaner.sv
// ----------------------------------------------------------------------------
// Level-set boundary cleaner
// Streaming removal of redundant boundary points from a raster label map.
// ----------------------------------------------------------------------------
// Usage:
// - Labels enter in raster order on the input channel, one per transfer. The
//   cleaned label of a pixel is produced when the pixel directly below it is
//   transferred, so results run one row behind the input. Pixels of the first
//   row give no result.
// - After the last pixel of a frame the source sends one row of flush
//   transfers (frame_width of them); each one drains one pixel of the last
//   row, and the final result carries last_of_frame.
// - The input transfer completing a result registers it in the output stage.
//   Throughput is one input transfer per cycle while o_in_ready is high;
//   the per-pixel test is a fixed four-neighbor sign check on a window held
//   in registers, fed by two line buffers with one read and one write port.
// - A two-entry output stage (output register plus skid register) lets the
//   input keep moving for one more transfer while the receiver stalls; the
//   input is held off only when both entries are full.
// - Reset clears the counters, the output stage and the size registers (both
//   1024). The line buffers are not cleared and need no clearing pass.
// - frame_width and frame_height must be written on the configuration port
//   only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module level_set_boundary_cleaner #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port
    input  logic                       i_cfg_we,
    input  lsbc_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [lsbc_pkg::CFG_DW-1:0] i_cfg_data,
    // Pixel input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lsbc_pkg::t_in_item         i_in_data,
    // Result output channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lsbc_pkg::t_out_item        o_out_data
);
    import lsbc_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int SW_A = (CW + 2 > RW + 1) ? CW + 2 : RW + 1;
    localparam int SW   = (SW_A > CFG_DW) ? SW_A : CFG_DW;

    // Size registers and counters
    logic [CFG_DW-1:0] r_frame_width;
    logic [CFG_DW-1:0] r_frame_height;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;

    // Line buffers and their registered read data
    t_label r_mem0 [MAX_WIDTH];
    t_label r_mem1 [MAX_WIDTH];
    t_label r_rd0;
    t_label r_rd1;

    // Window of the row above the incoming pixel
    t_label r_left;
    t_label r_centre;
    t_label r_first0;
    logic   r_rbyp;
    t_label r_rbyp_val;

    // Output stage
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;

    // Combinational signals
    logic [SW-1:0] w_size;
    logic [SW-1:0] h_size;
    logic [SW-1:0] col_ext;
    logic          draining;
    logic          row_end;
    logic          in_xfer;
    logic          step;
    logic          produce;
    logic          par;
    t_label        up_val;
    t_label        right_val;
    t_label        res;
    t_out_item     new_item;
    logic [CW-1:0] addr_a;
    logic [CW-1:0] addr_b;
    logic [CW-1:0] addr0;
    logic [CW-1:0] addr1;
    logic [SW-1:0] col_p2;
    logic          wr0;
    logic          wr1;
    logic          take;

    // Clamp the sizes and decode the position of the incoming item.
    always_comb begin
        if (r_frame_width == '0) begin
            w_size = SW'(1);
        end else if (SW'(r_frame_width) > SW'(MAX_WIDTH)) begin
            w_size = SW'(MAX_WIDTH);
        end else begin
            w_size = SW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_size = SW'(1);
        end else if (SW'(r_frame_height) > SW'(MAX_HEIGHT)) begin
            h_size = SW'(MAX_HEIGHT);
        end else begin
            h_size = SW'(r_frame_height);
        end
        col_ext  = SW'(r_col);
        draining = SW'(r_row) >= h_size;
        row_end  = (col_ext + SW'(1)) >= w_size;
        in_xfer  = i_in_valid && o_in_ready;
        // A flush counts only while the last row drains; a pixel then acts as one.
        step     = in_xfer && (draining || !i_in_data.flush);
        produce  = step && (r_row != '0);
        par      = r_row[0];
    end

    // Neighbor values: the buffer of the current row parity holds the row two
    // above, the other one holds the row directly above.
    always_comb begin
        up_val    = par ? r_rd1 : r_rd0;
        right_val = r_rbyp ? r_rbyp_val : (par ? r_rd0 : r_rd1);
        res = clean_label(r_centre,
                          r_row >= RW'(2), up_val,
                          r_col != '0, r_left,
                          !row_end, right_val,
                          !draining, i_in_data.label_in);
        new_item.label_out     = res;
        new_item.last_of_frame = draining && row_end;
    end

    // Prefetch addresses for the next item, split onto the two buffers.
    always_comb begin
        col_p2 = col_ext + SW'(2);
        addr_a = row_end ? CW'(1) : CW'(col_ext + SW'(1));
        if (row_end || col_p2 >= SW'(MAX_WIDTH)) begin
            addr_b = '0;
        end else begin
            addr_b = CW'(col_p2);
        end
        addr0 = par ? addr_b : addr_a;
        addr1 = par ? addr_a : addr_b;
        wr0   = step && !draining && !par;
        wr1   = step && !draining && par;
    end

    // Line buffer zero: one write at the current column, one registered read.
    always_ff @(posedge i_clk) begin
        if (wr0) begin
            r_mem0[r_col] <= i_in_data.label_in;
        end
        if (step) begin
            r_rd0 <= r_mem0[addr0];
        end
    end

    // Line buffer one.
    always_ff @(posedge i_clk) begin
        if (wr1) begin
            r_mem1[r_col] <= i_in_data.label_in;
        end
        if (step) begin
            r_rd1 <= r_mem1[addr1];
        end
    end

    // Window shift; payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_left     <= r_centre;
            r_rbyp_val <= i_in_data.label_in;
            if (row_end) begin
                r_centre <= (r_col == '0) ? i_in_data.label_in : r_first0;
            end else begin
                r_centre <= right_val;
            end
            if (r_col == '0 && !draining) begin
                r_first0 <= i_in_data.label_in;
            end
        end
    end

    // Counters, configuration and the read-during-write bypass flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DW'(1024);
            r_frame_height <= CFG_DW'(1024);
            r_col          <= '0;
            r_row          <= '0;
            r_rbyp         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (step) begin
                // The next row reads column one of the buffer written right now.
                r_rbyp <= row_end && !draining && (r_col == CW'(1));
                if (row_end) begin
                    r_col <= '0;
                    r_row <= draining ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Output register with a skid entry behind it.
    assign take       = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= produce;
                end
            end else if (produce) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : new_item;
        end else if (produce) begin
            r_skid <= new_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The skid entry is only ever filled behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // The skid entry fills only when the receiver stalls a waiting result.
    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid entry filled without a stall");

    // The final result of a frame returns the counters to the frame start.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && new_item.last_of_frame) |=> (r_row == '0 && r_col == '0))
        else $error("counters did not wrap after the last pixel of the frame");

endmodule
